FILE: rtl/core/bdq_pkg.sv
// package: sizes, payload types, action codes and cell controls for the deque
`timescale 1ns / 1ps

package bdq_pkg;

  localparam int DEPTH     = 1024;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CAP_W     = 11;
  localparam int CAP_RESET = 1024;

  // rear value gather tree: leaves per group and number of groups
  localparam int GRP_SIZE  = 32;
  localparam int NUM_GRP   = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_REAR  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_REAR   = 3'd3;
  localparam logic [2:0] ACT_STATUS     = 3'd4;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_REAR,
    CELL_POP_FRONT,
    CELL_POP_REAR
  } cell_op_e;

  typedef struct packed {
    cell_op_e                op;
    logic [DATA_W-1:0]       value;
  } cell_ctrl_t;

  typedef struct packed {
    logic [2:0]               action;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     empty_res;
    logic                     full_res;
  } out_t;

endpackage

FILE: rtl/core/bdq_cell.sv
// one deque cell: a data word and an occupied bit, shifting with its neighbors
`timescale 1ns / 1ps

module bdq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bdq_pkg::cell_ctrl_t        ctrl_i,
  input  logic                       left_valid_i,
  input  logic [bdq_pkg::DATA_W-1:0] left_data_i,
  input  logic                       right_valid_i,
  input  logic [bdq_pkg::DATA_W-1:0] right_data_i,
  output logic                       valid_o,
  output logic [bdq_pkg::DATA_W-1:0] data_o,
  output logic [bdq_pkg::DATA_W-1:0] rear_cand_o
);
  import bdq_pkg::*;

  logic              valid_d, valid_q;
  logic [DATA_W-1:0] data_d, data_q;

  // occupied bits form a thermometer: pushes grow it, pops shrink it
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    case (ctrl_i.op)
      CELL_PUSH_FRONT: begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
      end
      CELL_PUSH_REAR: begin
        valid_d = left_valid_i;
        // first free cell takes the new rear entry
        if (left_valid_i && !valid_q) begin
          data_d = ctrl_i.value;
        end
      end
      CELL_POP_FRONT: begin
        valid_d = right_valid_i;
        data_d  = right_data_i;
      end
      CELL_POP_REAR: begin
        valid_d = right_valid_i;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o     = valid_q;
  assign data_o      = data_q;
  // only the last occupied cell contributes to the rear value
  assign rear_cand_o = (valid_q && !right_valid_i) ? data_q : '0;

endmodule

FILE: rtl/core/bdq_pick.sv
// two-level registered or-tree that gathers the rear entry from the cell row
`timescale 1ns / 1ps

module bdq_pick (
  input  logic                                           clk_i,
  input  logic [bdq_pkg::DEPTH-1:0][bdq_pkg::DATA_W-1:0] cand_i,
  output logic [bdq_pkg::DATA_W-1:0]                     rear_o
);
  import bdq_pkg::*;

  logic [NUM_GRP-1:0][DATA_W-1:0] grp_d, grp_q;
  logic [DATA_W-1:0]              rear_d, rear_q;

  // at most one candidate is nonzero-masked, so an or picks it
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < DEPTH) begin
          grp_d[g] = grp_d[g] | cand_i[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_comb begin
    rear_d = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      rear_d = rear_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q  <= grp_d;
    rear_q <= rear_d;
  end

  assign rear_o = rear_q;

endmodule

FILE: rtl/core/bounded_double_ended_queue_top.sv
// top level: deque as a row of shifting cells, rear gather tree, control and apb register
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  in        input      in_valid_i / in_stall_o    in_data_i  (action, value)
//  out       output     out_valid_o / out_stall_i  out_data_o (ok, front, rear, empty, full)
//  cfg       input      apb psel/penable/pready    capacity at byte address 0
//
//  for every item the cell row updates on the accepting edge, then the rear entry goes
//  through two register levels of the gather tree, then the result loads.
//  the front entry always sits in cell zero; the rear is the last occupied cell.
//  reset empties the row (occupied bits cleared) and sets capacity to 1024; no clearing pass.
//  a result held by out_stall_i keeps the block from loading the next one; input stalls
//  until the pending result has moved into the output register.

module bounded_double_ended_queue_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  bdq_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output bdq_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdq_pkg::PADDR_W-1:0] paddr,
  input  logic [bdq_pkg::PDATA_W-1:0] pwdata,
  output logic [bdq_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import bdq_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_GATHER1 = 2'd1;
  localparam logic [1:0] ST_GATHER2 = 2'd2;
  localparam logic [1:0] ST_RESULT  = 2'd3;

  logic [1:0]       state_d, state_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] cap_eff;
  logic             ok_d, ok_q;
  logic             in_xfer;
  logic             can_push, can_pop;
  logic             out_load;
  logic             out_valid_q;
  out_t             out_d, out_q;
  cell_ctrl_t       ctrl;

  logic [DEPTH-1:0]             cell_valid;
  logic [DEPTH-1:0][DATA_W-1:0] cell_data;
  logic [DEPTH-1:0][DATA_W-1:0] rear_cand;
  logic [DATA_W-1:0]            rear_val;
  logic                         empty;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_CAPACITY) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

  always_comb begin
    if (32'(cap_q) > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign can_push   = count_q < cap_eff;
  assign can_pop    = count_q != '0;

  // action decode into a cell command and the new count
  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = in_data_i.value;
    count_d    = count_q;
    ok_d       = ok_q;
    if (in_xfer) begin
      ok_d = 1'b0;
      unique case (in_data_i.action)
        ACT_PUSH_FRONT: begin
          if (can_push) begin
            ctrl.op = CELL_PUSH_FRONT;
            count_d = count_q + 1'b1;
            ok_d    = 1'b1;
          end
        end
        ACT_PUSH_REAR: begin
          if (can_push) begin
            ctrl.op = CELL_PUSH_REAR;
            count_d = count_q + 1'b1;
            ok_d    = 1'b1;
          end
        end
        ACT_POP_FRONT: begin
          if (can_pop) begin
            ctrl.op = CELL_POP_FRONT;
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
          end
        end
        ACT_POP_REAR: begin
          if (can_pop) begin
            ctrl.op = CELL_POP_REAR;
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
          end
        end
        ACT_STATUS: begin
          ok_d = 1'b1;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  // row of cells, front entry in cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              left_valid, right_valid;
    logic [DATA_W-1:0] left_data, right_data;

    if (i == 0) begin : g_head
      assign left_valid = 1'b1;
      assign left_data  = ctrl.value;
    end else begin : g_body
      assign left_valid = cell_valid[i-1];
      assign left_data  = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_link
      assign right_valid = cell_valid[i+1];
      assign right_data  = cell_data[i+1];
    end

    bdq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_valid_i  (left_valid),
      .left_data_i   (left_data),
      .right_valid_i (right_valid),
      .right_data_i  (right_data),
      .valid_o       (cell_valid[i]),
      .data_o        (cell_data[i]),
      .rear_cand_o   (rear_cand[i])
    );
  end

  bdq_pick u_pick (
    .clk_i  (clk_i),
    .cand_i (rear_cand),
    .rear_o (rear_val)
  );

  // sequencer: wait out the gather tree, then load the output register
  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_xfer) state_d = ST_GATHER1;
      ST_GATHER1: state_d = ST_GATHER2;
      ST_GATHER2: state_d = ST_RESULT;
      ST_RESULT:  if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty = (count_q == '0);

  always_comb begin
    out_d.ok          = ok_q;
    out_d.front_value = empty ? '1 : cell_data[0];
    out_d.rear_value  = empty ? '1 : rear_val;
    out_d.empty_res   = empty;
    out_d.full_res    = (count_q >= cap_eff);
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // occupied bits must match the entry count
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == 32'(count_q))
    else $error("occupied cells disagree with entry count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(DEPTH))
    else $error("entry count beyond depth");

  a_head_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == (count_q != '0))
    else $error("front cell occupancy wrong");

  a_load_after_gather: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == ST_RESULT)
    else $error("result loaded outside result state");

endmodule
